@@ rtl/itcz_pkg.sv @@
// itcz_pkg: shared types and constants for the interval timer counter zero unit
package itcz_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  localparam logic [1:0] PORT_DATA0 = 2'd0;
  localparam logic [1:0] PORT_CTRL  = 2'd3;

  localparam logic [7:0] CW_MODE3_LOHI = 8'h36;
  localparam logic [7:0] CW_LATCH0     = 8'h00;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef struct packed {
    opcode_t    opcode;
    logic [1:0] port;
    logic [7:0] write_data;
  } item_t;

endpackage

@@ rtl/interval_timer_counter_zero_unit.sv @@
// interval_timer_counter_zero_unit: counter zero of an interval timer in square wave mode
//
//  channel | dir | tdata (low bit up)                 | tuser
//  in_     | in  | port[1:0], write_data[9:2], 0 pad  | opcode[1:0]
//  out_    | out | read_data[7:0], out_level[8],      | -
//          |     | out_rose[9], 0 pad                 |
//
// one item per cycle sustained while out_tready is high; an item goes into
// the input register, then the counter state and result register update
// from it when the result register is empty or out_tready is high.
// rst_n (synchronous) clears all counter state; the output level resets high.
// a stalled result holds in the output register while the input register
// still takes one more item; in_tready drops only when both are full.
module interval_timer_counter_zero_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [itcz_pkg::IN_TDATA_W-1:0]       in_tdata,   // port, write_data
  input  logic [1:0]                            in_tuser,   // opcode
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [itcz_pkg::OUT_TDATA_W-1:0]      out_tdata   // read_data, out_level, out_rose
);

  // input register
  itcz_pkg::item_t item_r;
  logic            item_vld_r;

  // result register
  logic [7:0] rd_r;
  logic       level_r;
  logic       rose_r;
  logic       out_vld_r;

  // counter state
  logic [15:0] ce_r, ce_nxt;
  logic [15:0] reload_r, reload_nxt;
  logic [7:0]  low_hold_r, low_hold_nxt;
  logic [15:0] olatch_r, olatch_nxt;
  logic        latch_held_r, latch_held_nxt;
  logic        rd_high_r, rd_high_nxt;
  logic        wr_high_r, wr_high_nxt;
  logic        pend_r, pend_nxt;
  logic        run_r, run_nxt;
  logic        ostate_r, ostate_nxt;
  logic [7:0]  rd_nxt;

  logic        advance;
  logic [16:0] eff;
  logic [16:0] dec;
  logic [16:0] eff_sub;
  logic [15:0] rd_src;

  assign advance   = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.opcode     <= itcz_pkg::opcode_t'(in_tuser);
      item_r.port       <= in_tdata[1:0];
      item_r.write_data <= in_tdata[9:2];
    end
  end

  // 0 stands for 65536
  assign eff     = (ce_r == 16'd0) ? 17'h10000 : {1'b0, ce_r};
  assign eff_sub = eff - dec;
  assign rd_src  = latch_held_r ? olatch_r : ce_r;

  always_comb begin
    if (eff[0]) begin
      dec = ostate_r ? 17'd1 : 17'd3;
    end else begin
      dec = 17'd2;
    end
  end

  always_comb begin
    ce_nxt         = ce_r;
    reload_nxt     = reload_r;
    low_hold_nxt   = low_hold_r;
    olatch_nxt     = olatch_r;
    latch_held_nxt = latch_held_r;
    rd_high_nxt    = rd_high_r;
    wr_high_nxt    = wr_high_r;
    pend_nxt       = pend_r;
    run_nxt        = run_r;
    ostate_nxt     = ostate_r;
    rd_nxt         = 8'd0;
    unique case (item_r.opcode)
      itcz_pkg::OP_TICK: begin
        if (!run_r) begin
          // first tick after a full count only loads
          if (pend_r) begin
            ce_nxt   = reload_r;
            pend_nxt = 1'b0;
            run_nxt  = 1'b1;
          end
        end else if (eff <= dec) begin
          ostate_nxt = !ostate_r;
          ce_nxt     = reload_r;
          pend_nxt   = 1'b0;
        end else begin
          ce_nxt = eff_sub[15:0];
        end
      end
      itcz_pkg::OP_WRITE: begin
        if (item_r.port == itcz_pkg::PORT_CTRL) begin
          if (item_r.write_data == itcz_pkg::CW_MODE3_LOHI) begin
            ostate_nxt     = 1'b1;
            run_nxt        = 1'b0;
            pend_nxt       = 1'b0;
            wr_high_nxt    = 1'b0;
            rd_high_nxt    = 1'b0;
            latch_held_nxt = 1'b0;
          end else if (item_r.write_data == itcz_pkg::CW_LATCH0) begin
            if (!latch_held_r) begin
              olatch_nxt     = ce_r;
              latch_held_nxt = 1'b1;
            end
          end
        end else if (item_r.port == itcz_pkg::PORT_DATA0) begin
          if (!wr_high_r) begin
            low_hold_nxt = item_r.write_data;
            wr_high_nxt  = 1'b1;
          end else begin
            reload_nxt  = {item_r.write_data, low_hold_r};
            wr_high_nxt = 1'b0;
            pend_nxt    = 1'b1;
          end
        end
      end
      itcz_pkg::OP_READ: begin
        if (item_r.port == itcz_pkg::PORT_DATA0) begin
          if (rd_high_r) begin
            rd_nxt         = rd_src[15:8];
            rd_high_nxt    = 1'b0;
            latch_held_nxt = 1'b0;
          end else begin
            rd_nxt      = rd_src[7:0];
            rd_high_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ce_r         <= 16'd0;
      reload_r     <= 16'd0;
      low_hold_r   <= 8'd0;
      olatch_r     <= 16'd0;
      latch_held_r <= 1'b0;
      rd_high_r    <= 1'b0;
      wr_high_r    <= 1'b0;
      pend_r       <= 1'b0;
      run_r        <= 1'b0;
      ostate_r     <= 1'b1;
    end else if (advance) begin
      ce_r         <= ce_nxt;
      reload_r     <= reload_nxt;
      low_hold_r   <= low_hold_nxt;
      olatch_r     <= olatch_nxt;
      latch_held_r <= latch_held_nxt;
      rd_high_r    <= rd_high_nxt;
      wr_high_r    <= wr_high_nxt;
      pend_r       <= pend_nxt;
      run_r        <= run_nxt;
      ostate_r     <= ostate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_r    <= rd_nxt;
      level_r <= ostate_nxt;
      rose_r  <= !ostate_r && ostate_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, rose_r, level_r, rd_r};

  // a rising edge always leaves the output high
  a_rose_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tdata[8])
    else $error("out_rose set with output low");

  // only port reads return data
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item_r.opcode != itcz_pkg::OP_READ |=> out_tdata[7:0] == 8'd0)
    else $error("read_data nonzero on a non-read item");

  // the input side never blocks while the result register is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_tready)
    else $error("in_tready low with empty result register");

  // output level moves only when an item is processed
  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(ostate_r))
    else $error("output level changed without an item");

endmodule
